FILE: rtl/bba_pkg.sv
// Shared constants for the buddy block allocator.
// No dependencies.
package bba_pkg;
  localparam int unsigned CAPACITY  = 16384;
  localparam int unsigned MIN_BLOCK = 256;
  localparam int unsigned CAP_LOG   = 14;
  localparam int unsigned MIN_LOG   = 8;
  localparam int unsigned LEVELS    = CAP_LOG - MIN_LOG + 1;
  localparam int unsigned NODES     = 2 * (CAPACITY / MIN_BLOCK) - 1;
  localparam int unsigned NODE_W    = $clog2(NODES);
  localparam int unsigned LVL_W     = $clog2(LEVELS);

  localparam logic [1:0] RES_DONE  = 2'd0;
  localparam logic [1:0] RES_NOFIT = 2'd1;
  localparam logic [1:0] RES_NOID  = 2'd2;

  localparam logic [1:0] NODE_FREE  = 2'd0;
  localparam logic [1:0] NODE_SPLIT = 2'd1;
  localparam logic [1:0] NODE_ALLOC = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
endpackage

FILE: rtl/buddy_block_allocator.sv
// Binary buddy allocator: node tree in a RAM walked by a small sequencer. Depends on bba_pkg.
// Each node visited is read, then evaluated; a split writes the right child; an ascent step
// adds a state; free adds a sibling read and evaluate per merge level. The tree has 127 nodes.
// One request at a time: busy_o is high from the transfer until the result strobe.
// The result is shown for one cycle on valid_o; the receiver cannot stall.
// Reset clears the root to free and free space to capacity; other nodes need no clearing.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [7:0]  req_id_i,
  input  logic [14:0] req_size_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [13:0] block_offset_o,
  output logic [14:0] block_bytes_o,
  output logic [14:0] free_space_o
);
  localparam int unsigned NW = bba_pkg::NODE_W;
  localparam int unsigned LW = bba_pkg::LVL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_WSPL, S_ASC, S_MRD, S_MEV
  } state_e;

  state_e         state_q;
  logic [NW-1:0]  node_q;
  logic [LW-1:0]  lvl_q;
  logic           fresh_q;
  logic           type_q;
  logic [7:0]     id_q;
  logic [14:0]    size_q;
  logic [1:0]     root_q;
  logic [14:0]    free_total_q;
  logic           valid_q;
  logic [1:0]     status_q;
  logic [13:0]    off_q;
  logic [14:0]    bytes_q;

  logic [9:0]     mem [bba_pkg::NODES];
  logic [9:0]     rdata_q;
  logic           rd_root_q;
  logic [NW-1:0]  raddr;
  logic           we;
  logic [NW-1:0]  waddr;
  logic [9:0]     wdata;

  logic [1:0]     cur_st;
  logic [LW-1:0]  want_lvl;
  logic           bad_size;
  logic [NW-1:0]  left_c, right_c, parent, sibling;
  logic [NW-1:0]  pos;
  logic [13:0]    cur_off;
  logic [14:0]    cur_bytes;

  always_comb begin
    want_lvl = '0;
    for (int l = 0; l < int'(bba_pkg::LEVELS); l++) begin
      if ((bba_pkg::CAPACITY >> l) >= 32'(size_q)) want_lvl = LW'(l);
    end
  end

  assign bad_size  = (size_q == 15'd0) || (32'(size_q) > bba_pkg::CAPACITY);
  assign left_c    = {node_q[NW-2:0], 1'b1};
  assign right_c   = left_c + NW'(1);
  assign parent    = (node_q - NW'(1)) >> 1;
  assign sibling   = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
  assign pos       = node_q + NW'(1) - (NW'(1) << lvl_q);
  assign cur_off   = 14'(pos) << (4'(bba_pkg::CAP_LOG) - 4'(lvl_q));
  assign cur_bytes = 15'(bba_pkg::CAPACITY) >> lvl_q;
  assign cur_st    = fresh_q ? bba_pkg::NODE_FREE : (rd_root_q ? root_q : rdata_q[9:8]);
  assign raddr     = (state_q == S_MRD) ? sibling : node_q;

  always_comb begin
    we    = 1'b0;
    waddr = node_q;
    wdata = {bba_pkg::NODE_FREE, id_q};
    case (state_q)
      S_EV: begin
        if (type_q == bba_pkg::REQ_ALLOC) begin
          if (cur_st == bba_pkg::NODE_FREE) begin
            we    = 1'b1;
            wdata = {(lvl_q == want_lvl) ? bba_pkg::NODE_ALLOC : bba_pkg::NODE_SPLIT, id_q};
          end
        end else if (cur_st == bba_pkg::NODE_ALLOC && rdata_q[7:0] == id_q) begin
          we = 1'b1;
        end
      end
      S_WSPL: begin
        we    = 1'b1;
        waddr = right_c;
      end
      S_MEV: begin
        if (rdata_q[9:8] == bba_pkg::NODE_FREE) begin
          we    = 1'b1;
          waddr = parent;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q   <= mem[raddr];
    rd_root_q <= (raddr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_q       <= '0;
      lvl_q        <= '0;
      fresh_q      <= 1'b0;
      root_q       <= bba_pkg::NODE_FREE;
      free_total_q <= 15'(bba_pkg::CAPACITY);
      valid_q      <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (we && waddr == '0) root_q <= wdata[9:8];
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            type_q  <= req_type_i;
            id_q    <= req_id_i;
            size_q  <= req_size_i;
            node_q  <= '0;
            lvl_q   <= '0;
            fresh_q <= 1'b0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (type_q == bba_pkg::REQ_ALLOC && bad_size) begin
            status_q <= bba_pkg::RES_NOFIT;
            off_q    <= '0;
            bytes_q  <= '0;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_EV;
          end
        end
        S_EV: begin
          state_q <= S_ASC;
          if (type_q == bba_pkg::REQ_ALLOC) begin
            if (cur_st == bba_pkg::NODE_FREE && lvl_q == want_lvl) begin
              free_total_q <= free_total_q - cur_bytes;
              status_q     <= bba_pkg::RES_DONE;
              off_q        <= cur_off;
              bytes_q      <= cur_bytes;
              valid_q      <= 1'b1;
              state_q      <= S_IDLE;
            end else if (cur_st == bba_pkg::NODE_FREE && lvl_q < want_lvl) begin
              state_q <= S_WSPL;
            end else if (cur_st == bba_pkg::NODE_SPLIT && lvl_q < want_lvl) begin
              node_q  <= left_c;
              lvl_q   <= lvl_q + LW'(1);
              state_q <= S_RD;
            end
          end else begin
            if (cur_st == bba_pkg::NODE_ALLOC && rdata_q[7:0] == id_q) begin
              free_total_q <= free_total_q + cur_bytes;
              status_q     <= bba_pkg::RES_DONE;
              off_q        <= cur_off;
              bytes_q      <= cur_bytes;
              if (node_q == '0) begin
                valid_q <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                state_q <= S_MRD;
              end
            end else if (cur_st == bba_pkg::NODE_SPLIT &&
                         lvl_q < LW'(bba_pkg::LEVELS - 1)) begin
              node_q  <= left_c;
              lvl_q   <= lvl_q + LW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_WSPL: begin
          node_q  <= left_c;
          lvl_q   <= lvl_q + LW'(1);
          fresh_q <= 1'b1;
          state_q <= S_RD;
        end
        S_ASC: begin
          if (node_q == '0) begin
            status_q <= (type_q == bba_pkg::REQ_ALLOC) ? bba_pkg::RES_NOFIT
                                                       : bba_pkg::RES_NOID;
            off_q    <= '0;
            bytes_q  <= '0;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else if (node_q[0]) begin
            node_q  <= node_q + NW'(1);
            state_q <= S_RD;
          end else begin
            node_q <= parent;
            lvl_q  <= lvl_q - LW'(1);
          end
        end
        S_MRD: state_q <= S_MEV;
        S_MEV: begin
          if (rdata_q[9:8] == bba_pkg::NODE_FREE && parent != '0) begin
            node_q  <= parent;
            lvl_q   <= lvl_q - LW'(1);
            state_q <= S_MRD;
          end else begin
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign block_offset_o = off_q;
  assign block_bytes_o  = bytes_q;
  assign free_space_o   = free_total_q;

`ifndef SYNTHESIS
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result strobe while busy");
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_space_o) <= bba_pkg::CAPACITY) else $error("free space above capacity");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != bba_pkg::RES_DONE) |-> (block_bytes_o == 15'd0))
    else $error("failed request reports a block");
`endif
endmodule
